>>> hdl/rfft_pkg.sv
// rfft_pkg: widths, state codes, control struct and twiddle rom for the fft block
// depends on nothing; used by rfft_bfly and radix2_fft
package rfft_pkg;

  localparam int MAX_LOG2    = 10;
  localparam int MAX_PTS     = 1 << MAX_LOG2;
  localparam int HALF_PTS    = MAX_PTS >> 1;
  localparam int PTR_BITS    = MAX_LOG2;
  localparam int BF_BITS     = MAX_LOG2 - 1;
  localparam int LOG_BITS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int TW_FRAC     = 15;
  localparam int TW_BITS     = TW_FRAC + 2;
  localparam int OUT_BITS    = 27;
  localparam int WORD_BITS   = 2 * OUT_BITS;
  localparam int TWW_BITS    = 2 * TW_BITS;
  localparam int PROD_BITS   = TW_BITS + OUT_BITS;
  localparam int ACC_BITS    = PROD_BITS + 1;
  localparam int T_BITS      = ACC_BITS - TW_FRAC;
  localparam int SUM_BITS    = T_BITS + 1;
  localparam int ANG_FRAC    = 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [63:0] DEN_C [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                        64'd90, 64'd132, 64'd182, 64'd240};
  localparam logic [63:0] DEN_S [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                        64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [2:0] {
    ST_IDLE, ST_RA, ST_RB, ST_MUL, ST_RND, ST_WA, ST_WB
  } state_e;

  typedef struct packed {
    logic a_en;
    logic mul_en;
    logic rnd_en;
  } bf_ctrl_t;

  typedef logic [HALF_PTS-1:0][TWW_BITS-1:0] tw_rom_t;

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> ANG_FRAC;
  endfunction

  function automatic logic [TW_BITS-1:0] round_q30(logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << (ANG_FRAC - TW_FRAC - 1))) >> (ANG_FRAC - TW_FRAC);
    return r[TW_BITS-1:0];
  endfunction

  // cos - j sin table, angle folded into the first octant
  function automatic tw_rom_t build_rom();
    tw_rom_t rom;
    logic [63:0] th, ts, tc, sum_s, sum_c, s, c;
    logic [TW_BITS-1:0] cv, sv;
    int q, m, r;
    logic neg, swp;
    q = MAX_PTS / 4;
    for (int k = 0; k < HALF_PTS; k++) begin
      neg = (k > q);
      m = neg ? 2 * q - k : k;
      swp = (2 * m > q);
      r = swp ? q - m : m;
      th = (PI_Q30 * 64'(r)) >> (MAX_LOG2 - 1);
      ts = th;
      sum_s = th;
      tc = 64'd1 << ANG_FRAC;
      sum_c = tc;
      for (int n = 0; n < 8; n++) begin
        tc = q30_mul(q30_mul(tc, th), th) / DEN_C[n];
        ts = q30_mul(q30_mul(ts, th), th) / DEN_S[n];
        if (n % 2 == 0) begin
          sum_c = sum_c - tc;
          sum_s = sum_s - ts;
        end else begin
          sum_c = sum_c + tc;
          sum_s = sum_s + ts;
        end
      end
      s = swp ? sum_c : sum_s;
      c = swp ? sum_s : sum_c;
      cv = round_q30(c);
      sv = round_q30(s);
      rom[k] = {neg ? -cv : cv, -sv};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_rom();

  function automatic logic [PTR_BITS-1:0] bit_rev(logic [PTR_BITS-1:0] v,
                                                  logic [LOG_BITS-1:0] lg);
    logic [PTR_BITS-1:0] r;
    for (int i = 0; i < PTR_BITS; i++) r[i] = v[PTR_BITS-1-i];
    return r >> (LOG_BITS'(MAX_LOG2) - lg);
  endfunction

  function automatic logic [OUT_BITS-1:0] sat_out(logic signed [SUM_BITS-1:0] v);
    logic [OUT_BITS-1:0] hi, lo;
    hi = {1'b0, {(OUT_BITS-1){1'b1}}};
    lo = {1'b1, {(OUT_BITS-1){1'b0}}};
    if (v > $signed(SUM_BITS'($signed(hi)))) return hi;
    if (v < $signed(SUM_BITS'($signed(lo)))) return lo;
    return v[OUT_BITS-1:0];
  endfunction

endpackage

>>> hdl/rfft_bfly.sv
// rfft_bfly: butterfly datapath, twiddle product, rounding and saturating add/sub
// depends on rfft_pkg
module rfft_bfly (
  input  logic                              clk_i,
  input  rfft_pkg::bf_ctrl_t                ctrl_i,
  input  logic [rfft_pkg::WORD_BITS-1:0]    rd_i,
  input  logic [rfft_pkg::TWW_BITS-1:0]     tw_i,
  output logic [rfft_pkg::WORD_BITS-1:0]    sum_o,
  output logic [rfft_pkg::WORD_BITS-1:0]    dif_o
);

  localparam int OB = rfft_pkg::OUT_BITS;
  localparam int TB = rfft_pkg::TW_BITS;

  logic signed [OB-1:0] a_re_q, a_im_q, b_re, b_im;
  logic signed [TB-1:0] w_re, w_im;
  logic signed [rfft_pkg::PROD_BITS-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [rfft_pkg::ACC_BITS-1:0]  acc_re, acc_im;
  logic signed [rfft_pkg::T_BITS-1:0]    t_re_q, t_im_q;
  logic signed [rfft_pkg::SUM_BITS-1:0]  s_re, s_im, d_re, d_im;

  assign b_re = rd_i[2*OB-1:OB];
  assign b_im = rd_i[OB-1:0];
  assign w_re = tw_i[2*TB-1:TB];
  assign w_im = tw_i[TB-1:0];

  // round half up: add half an lsb then drop the twiddle fraction
  assign acc_re = rfft_pkg::ACC_BITS'(p_rr_q) - rfft_pkg::ACC_BITS'(p_ii_q)
                + rfft_pkg::ACC_BITS'(1 << (rfft_pkg::TW_FRAC - 1));
  assign acc_im = rfft_pkg::ACC_BITS'(p_ri_q) + rfft_pkg::ACC_BITS'(p_ir_q)
                + rfft_pkg::ACC_BITS'(1 << (rfft_pkg::TW_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_en) begin
      a_re_q <= b_re;
      a_im_q <= b_im;
    end
    if (ctrl_i.mul_en) begin
      p_rr_q <= w_re * b_re;
      p_ii_q <= w_im * b_im;
      p_ri_q <= w_re * b_im;
      p_ir_q <= w_im * b_re;
    end
    if (ctrl_i.rnd_en) begin
      t_re_q <= acc_re[rfft_pkg::ACC_BITS-1:rfft_pkg::TW_FRAC];
      t_im_q <= acc_im[rfft_pkg::ACC_BITS-1:rfft_pkg::TW_FRAC];
    end
  end

  assign s_re = rfft_pkg::SUM_BITS'(a_re_q) + rfft_pkg::SUM_BITS'(t_re_q);
  assign s_im = rfft_pkg::SUM_BITS'(a_im_q) + rfft_pkg::SUM_BITS'(t_im_q);
  assign d_re = rfft_pkg::SUM_BITS'(a_re_q) - rfft_pkg::SUM_BITS'(t_re_q);
  assign d_im = rfft_pkg::SUM_BITS'(a_im_q) - rfft_pkg::SUM_BITS'(t_im_q);

  assign sum_o = {rfft_pkg::sat_out(s_re), rfft_pkg::sat_out(s_im)};
  assign dif_o = {rfft_pkg::sat_out(d_re), rfft_pkg::sat_out(d_im)};

endmodule

>>> hdl/radix2_fft.sv
// radix2_fft: in-place radix-2 dit fft over one frame memory with a shared butterfly
// depends on rfft_pkg and rfft_bfly
//
// channel   direction  handshake              payload
// request   in         start high, busy low   opcode_i, sample_re_i, sample_im_i
// result    out        done_o one cycle       out_valid_o, out_re_o, out_im_o,
//                                              bin_index_o, last_bin_o
// config    in         cfg_valid_i/cfg_ready_o cfg_data_i (size_log2)
//
// samples go straight to bit-reversed addresses; the last push of a frame starts
// the transform, busy meanwhile; on the single read / single write frame memory
// each butterfly reads a, reads b, multiplies, rounds, writes a and writes b
// a read's result shows on the next cycle; reads can follow
// back to back; the receiver cannot stall, so there is no output back pressure
// reset clears counters, flags and size (to 10); the frame memory holds no reset
module radix2_fft (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic signed [rfft_pkg::SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [rfft_pkg::SAMPLE_BITS-1:0] sample_im_i,
  output logic                                done_o,
  output logic                                out_valid_o,
  output logic signed [rfft_pkg::OUT_BITS-1:0] out_re_o,
  output logic signed [rfft_pkg::OUT_BITS-1:0] out_im_o,
  output logic [rfft_pkg::PTR_BITS-1:0]       bin_index_o,
  output logic                                last_bin_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rfft_pkg::LOG_BITS-1:0]       cfg_data_i
);

  localparam int PB = rfft_pkg::PTR_BITS;
  localparam int BB = rfft_pkg::BF_BITS;
  localparam int LB = rfft_pkg::LOG_BITS;
  localparam int OB = rfft_pkg::OUT_BITS;
  localparam int XB = rfft_pkg::OUT_BITS - rfft_pkg::SAMPLE_BITS;

  rfft_pkg::state_e state_q, state_d;
  rfft_pkg::bf_ctrl_t bf_ctrl;

  logic [LB-1:0] size_q, lg;
  logic [PB-1:0] nmask, load_q, load_d, rdcnt_q, rdcnt_d;
  logic          ready_q, ready_d;
  logic [LB-1:0] stage_q, stage_d;
  logic [BB-1:0] bf_q, bf_d, hmask;
  logic [PB-1:0] hbit, addr_a, addr_b, w_full;
  logic [BB-1:0] w_idx;

  logic          accept, cfg_wr, push, rd_req;

  // frame memory, one write and one registered read port
  logic [rfft_pkg::WORD_BITS-1:0] mem [rfft_pkg::MAX_PTS];
  logic [rfft_pkg::WORD_BITS-1:0] rdata_q, wdata;
  logic [PB-1:0]                  raddr, waddr;
  logic                           we;

  logic [rfft_pkg::TWW_BITS-1:0]  tw_q;
  logic [rfft_pkg::WORD_BITS-1:0] sum_w, dif_w;

  // result registers
  logic          strobe_q, oval_q, last_q;
  logic [PB-1:0] idx_q;

  // sizes out of range are clamped
  always_comb begin
    if (size_q == '0) lg = LB'(1);
    else if (size_q > LB'(rfft_pkg::MAX_LOG2)) lg = LB'(rfft_pkg::MAX_LOG2);
    else lg = size_q;
  end
  assign nmask = PB'((1 << lg) - 1);

  assign busy        = (state_q != rfft_pkg::ST_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign push        = accept && !opcode_i;
  assign rd_req      = accept && opcode_i;

  // butterfly addressing: insert a zero at bit stage-1 of the butterfly count
  assign hbit   = PB'(1) << (stage_q - LB'(1));
  assign hmask  = hbit[BB-1:0] - BB'(1);
  assign addr_a = ({1'b0, bf_q & ~hmask} << 1) | {1'b0, bf_q & hmask};
  assign addr_b = addr_a | hbit;
  assign w_full = {1'b0, bf_q & hmask} << (LB'(rfft_pkg::MAX_LOG2) - stage_q);
  assign w_idx  = w_full[BB-1:0];

  always_comb begin
    state_d = state_q;
    load_d  = load_q;
    rdcnt_d = rdcnt_q;
    ready_d = ready_q;
    stage_d = stage_q;
    bf_d    = bf_q;
    bf_ctrl = '0;
    raddr   = rdcnt_q;
    waddr   = addr_a;
    wdata   = sum_w;
    we      = 1'b0;
    unique case (state_q)
      rfft_pkg::ST_IDLE: begin
        if (push) begin
          // a push after a finished frame starts over
          we    = 1'b1;
          waddr = rfft_pkg::bit_rev(ready_q ? '0 : load_q, lg);
          wdata = {{XB{sample_re_i[rfft_pkg::SAMPLE_BITS-1]}}, sample_re_i,
                   {XB{sample_im_i[rfft_pkg::SAMPLE_BITS-1]}}, sample_im_i};
          ready_d = 1'b0;
          rdcnt_d = '0;
          if ((ready_q ? '0 : load_q) == nmask) begin
            load_d  = '0;
            stage_d = LB'(1);
            bf_d    = '0;
            state_d = rfft_pkg::ST_RA;
          end else begin
            load_d = (ready_q ? '0 : load_q) + PB'(1);
          end
        end else if (rd_req && ready_q) begin
          raddr = rdcnt_q;
          if (rdcnt_q == nmask) begin
            ready_d = 1'b0;
            rdcnt_d = '0;
          end else begin
            rdcnt_d = rdcnt_q + PB'(1);
          end
        end
        if (cfg_wr) begin
          load_d  = '0;
          rdcnt_d = '0;
          ready_d = 1'b0;
        end
      end
      rfft_pkg::ST_RA: begin
        raddr   = addr_a;
        state_d = rfft_pkg::ST_RB;
      end
      rfft_pkg::ST_RB: begin
        raddr        = addr_b;
        bf_ctrl.a_en = 1'b1;
        state_d      = rfft_pkg::ST_MUL;
      end
      rfft_pkg::ST_MUL: begin
        bf_ctrl.mul_en = 1'b1;
        state_d        = rfft_pkg::ST_RND;
      end
      rfft_pkg::ST_RND: begin
        bf_ctrl.rnd_en = 1'b1;
        state_d        = rfft_pkg::ST_WA;
      end
      rfft_pkg::ST_WA: begin
        we      = 1'b1;
        waddr   = addr_a;
        wdata   = sum_w;
        state_d = rfft_pkg::ST_WB;
      end
      rfft_pkg::ST_WB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = dif_w;
        if (bf_q == nmask[PB-1:1]) begin
          bf_d = '0;
          if (stage_q == lg) begin
            ready_d = 1'b1;
            rdcnt_d = '0;
            state_d = rfft_pkg::ST_IDLE;
          end else begin
            stage_d = stage_q + LB'(1);
            state_d = rfft_pkg::ST_RA;
          end
        end else begin
          bf_d    = bf_q + BB'(1);
          state_d = rfft_pkg::ST_RA;
        end
      end
      default: state_d = rfft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rfft_pkg::ST_IDLE;
      size_q   <= LB'(rfft_pkg::MAX_LOG2);
      load_q   <= '0;
      rdcnt_q  <= '0;
      ready_q  <= 1'b0;
      stage_q  <= LB'(1);
      bf_q     <= '0;
      strobe_q <= 1'b0;
      oval_q   <= 1'b0;
      last_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      load_q   <= load_d;
      rdcnt_q  <= rdcnt_d;
      ready_q  <= ready_d;
      stage_q  <= stage_d;
      bf_q     <= bf_d;
      if (cfg_wr) size_q <= cfg_data_i;
      strobe_q <= rd_req;
      oval_q   <= rd_req && ready_q;
      last_q   <= rd_req && ready_q && (rdcnt_q == nmask);
      idx_q    <= (rd_req && ready_q) ? rdcnt_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    tw_q    <= rfft_pkg::TW_ROM[w_idx];
  end

  rfft_bfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bf_ctrl),
    .rd_i   (rdata_q),
    .tw_i   (tw_q),
    .sum_o  (sum_w),
    .dif_o  (dif_w)
  );

  assign done_o      = strobe_q;
  assign out_valid_o = oval_q;
  assign out_re_o    = oval_q ? rdata_q[2*OB-1:OB] : '0;
  assign out_im_o    = oval_q ? rdata_q[OB-1:0] : '0;
  assign bin_index_o = idx_q;
  assign last_bin_o  = last_q;

  // no result strobe while the transform runs
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o) else $error("result strobe during transform");

  // memory writes only on pushes and butterfly write-back
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == rfft_pkg::ST_IDLE || state_q == rfft_pkg::ST_WA ||
            state_q == rfft_pkg::ST_WB)) else $error("stray memory write");

  // a frame becomes ready only at the end of the last butterfly
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(state_q == rfft_pkg::ST_WB))
    else $error("frame ready outside transform end");

endmodule
